/* rtl/core/sm2pr_pkg.sv */
// ----------------------------------------------------------------------------
// sm2pr_pkg
// Types and constants for the SM2 prime-field reduction pipeline.
// ----------------------------------------------------------------------------
package sm2pr_pkg;

    localparam int WORD_W  = 32;
    localparam int LIMB_W  = 64;
    localparam int HALF_W  = 256;
    localparam int NUM_WRD = HALF_W / WORD_W;

    // Column sums: word plus up to 13 folded words, and no lower than -4 words.
    localparam int SUM_W   = WORD_W + 6;
    localparam int HI_W    = SUM_W - WORD_W;
    // Column sums recombined: 256 bits plus a small signed top.
    localparam int VAL_W   = HALF_W + HI_W;
    // Residue candidates after the second fold: inside (-p, 2p).
    localparam int RES_W   = HALF_W + 2;

    localparam int COEF_W  = 3;

    // 2^256 == 2^224 + 2^96 - 2^64 + 1 (mod p)
    localparam int SHIFT_HI  = 224;
    localparam int SHIFT_MID = 96;
    localparam int SHIFT_LO  = 64;

    localparam logic [HALF_W-1:0] PRIME =
        256'hFFFFFFFE_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000_FFFFFFFF_FFFFFFFF;

    // COEF[k][j]: weight of upper word 8+k in lower word j after full folding.
    localparam logic signed [COEF_W-1:0] COEF [NUM_WRD][NUM_WRD] = '{
        '{ 3'sd1,  3'sd0, -3'sd1,  3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1 },
        '{ 3'sd1,  3'sd1, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd0,  3'sd1 },
        '{ 3'sd1,  3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd0,  3'sd1 },
        '{ 3'sd1,  3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd0,  3'sd1,  3'sd1 },
        '{ 3'sd1,  3'sd1,  3'sd0,  3'sd1,  3'sd1,  3'sd0,  3'sd0,  3'sd2 },
        '{ 3'sd2,  3'sd1, -3'sd1,  3'sd2,  3'sd1,  3'sd1,  3'sd0,  3'sd2 },
        '{ 3'sd2,  3'sd2, -3'sd1,  3'sd1,  3'sd2,  3'sd1,  3'sd1,  3'sd2 },
        '{ 3'sd2,  3'sd2,  3'sd0,  3'sd1,  3'sd1,  3'sd2,  3'sd1,  3'sd3 }
    };

    typedef struct packed {
        logic [LIMB_W-1:0] limb7;
        logic [LIMB_W-1:0] limb6;
        logic [LIMB_W-1:0] limb5;
        logic [LIMB_W-1:0] limb4;
        logic [LIMB_W-1:0] limb3;
        logic [LIMB_W-1:0] limb2;
        logic [LIMB_W-1:0] limb1;
        logic [LIMB_W-1:0] limb0;
    } t_in_item;

    typedef struct packed {
        logic [LIMB_W-1:0] rem3;
        logic [LIMB_W-1:0] rem2;
        logic [LIMB_W-1:0] rem1;
        logic [LIMB_W-1:0] rem0;
    } t_out_item;

endpackage

/* rtl/core/sm2_prime_reduce.sv */
// ----------------------------------------------------------------------------
// sm2_prime_reduce: 512-bit value reduced modulo the SM2 prime
// Five register stages lie between an accepted item and its valid result.
// Throughput: one item per cycle unless a waiting result is stalled; every stage is a fixed-depth add.
// Reset clears the stage valid bits only; a stalled output freezes all stages.
// ----------------------------------------------------------------------------
module sm2_prime_reduce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sm2pr_pkg::t_in_item  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output sm2pr_pkg::t_out_item o_out_data,
    input  logic                 i_out_stall
);

    localparam int NUM_STG = 5;
    localparam int WORD_W  = sm2pr_pkg::WORD_W;
    localparam int NUM_WRD = sm2pr_pkg::NUM_WRD;
    localparam int SUM_W   = sm2pr_pkg::SUM_W;
    localparam int HI_W    = sm2pr_pkg::HI_W;
    localparam int VAL_W   = sm2pr_pkg::VAL_W;
    localparam int RES_W   = sm2pr_pkg::RES_W;
    localparam int HALF_W  = sm2pr_pkg::HALF_W;

    logic                       w_en;
    logic [NUM_STG-1:0]         r_valid;

    logic [2*HALF_W-1:0]        w_in_flat;
    logic signed [SUM_W-1:0]    n_sum [NUM_WRD];
    logic signed [SUM_W-1:0]    r_sum [NUM_WRD];
    logic [VAL_W-1:0]           n_val;
    logic [VAL_W-1:0]           r_val;
    logic [HALF_W-1:0]          r_low;
    logic signed [RES_W-1:0]    n_fold;
    logic signed [RES_W-1:0]    r_fold;
    logic signed [RES_W-1:0]    n_res;
    logic signed [RES_W-1:0]    r_res;
    logic signed [RES_W-1:0]    w_plus_p;
    logic signed [RES_W-1:0]    w_minus_p;
    logic [HALF_W-1:0]          n_out;
    logic [HALF_W-1:0]          r_out;

    // whole pipe moves together; it only holds while a finished item waits
    assign w_en        = !(r_valid[NUM_STG-1] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_valid[NUM_STG-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NUM_STG-2:0], i_in_valid};
        end
    end

    // stage 1: column sums, each upper word spread over the lower words
    assign w_in_flat = i_in_data;

    always_comb begin
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < NUM_WRD; j++) begin
            acc = $signed({{(SUM_W-WORD_W){1'b0}}, w_in_flat[j*WORD_W +: WORD_W]});
            for (int k = 0; k < NUM_WRD; k++) begin
                acc = acc + SUM_W'(sm2pr_pkg::COEF[k][j]) *
                      $signed({{(SUM_W-WORD_W){1'b0}},
                               w_in_flat[(NUM_WRD+k)*WORD_W +: WORD_W]});
            end
            n_sum[j] = acc;
        end
    end

    // stage 2: recombine columns; signed carries split into add and subtract words
    always_comb begin
        logic [VAL_W-1:0] lo_part;
        logic [VAL_W-1:0] pos_part;
        logic [VAL_W-1:0] neg_part;
        logic [HI_W-1:0]  hi;
        lo_part  = '0;
        pos_part = '0;
        neg_part = '0;
        for (int j = 0; j < NUM_WRD; j++) begin
            lo_part[j*WORD_W +: WORD_W] = r_sum[j][WORD_W-1:0];
            hi = r_sum[j][SUM_W-1:WORD_W];
            if (hi[HI_W-1]) begin
                neg_part[(j+1)*WORD_W +: HI_W] = -hi;
            end else begin
                pos_part[(j+1)*WORD_W +: HI_W] = hi;
            end
        end
        n_val = lo_part + pos_part - neg_part;
    end

    // stage 3: small signed top folded again with the prime's identity
    always_comb begin
        logic signed [RES_W-1:0] top;
        top    = RES_W'($signed(r_val[VAL_W-1:HALF_W]));
        n_fold = (top <<< sm2pr_pkg::SHIFT_HI) + (top <<< sm2pr_pkg::SHIFT_MID)
               - (top <<< sm2pr_pkg::SHIFT_LO) + top;
    end

    // stage 4: value now lies in (-p, 2p)
    assign n_res = $signed({2'b00, r_low}) + r_fold;

    // stage 5: pick the one candidate inside [0, p)
    assign w_plus_p  = r_res + $signed({2'b00, sm2pr_pkg::PRIME});
    assign w_minus_p = r_res - $signed({2'b00, sm2pr_pkg::PRIME});

    always_comb begin
        priority if (r_res[RES_W-1]) begin
            n_out = w_plus_p[HALF_W-1:0];
        end else if (!w_minus_p[RES_W-1]) begin
            n_out = w_minus_p[HALF_W-1:0];
        end else begin
            n_out = r_res[HALF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum  <= n_sum;
            r_val  <= n_val;
            r_low  <= r_val[HALF_W-1:0];
            r_fold <= n_fold;
            r_res  <= n_res;
            r_out  <= n_out;
        end
    end

endmodule

/* rtl/core/sm2pr_checker.sv */
// ----------------------------------------------------------------------------
// sm2pr_checker
// Port-level checks on the reduction pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module sm2pr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input sm2pr_pkg::t_out_item o_out_data,
    input logic                 i_out_stall
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // every result is fully reduced
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({o_out_data.rem3, o_out_data.rem2, o_out_data.rem1,
                          o_out_data.rem0} < sm2pr_pkg::PRIME))
        else $error("result not below p");

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // an item that meets no stall on its way through the stages comes out
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall ##1 !o_in_stall ##1 !o_in_stall
        ##1 !o_in_stall ##1 !o_in_stall |=> o_out_valid)
        else $error("item lost in pipeline");

endmodule

bind sm2_prime_reduce sm2pr_checker u_sm2pr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
